// ===== rtl/core/sobel_edge_threshold_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel edge threshold block
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// Consequent checked in the same cycle as the trigger.
`define SET_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the trigger.
`define SET_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/set_pkg.sv =====
// ----------------------------------------------------------------------------
// set_pkg
// Shared types and constants of the Sobel edge threshold block.
// ----------------------------------------------------------------------------
package set_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 11;
  localparam int THR_W     = 11;
  localparam int SIZE_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int GRAD_W    = 11;
  localparam int SQ_W      = 20;
  localparam int THR_SQ_W  = 22;

  localparam int THRESHOLD_RESET = 60;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int MIN_SIZE        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_IMAGE_WIDTH    = 2'd1,
    CFG_IMAGE_HEIGHT   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray_pixel;
    logic             frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic               edge_flag;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_done;
  } edge_out_t;

endpackage

// ===== rtl/core/sobel_edge_threshold.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// 3x3 Sobel edge detector on a raster gray stream with a squared threshold.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel in raster order, one request per pixel;
// frame_start forces the pixel to position (0,0). For every interior pixel
// the block sends one request on the out channel when its lower-right
// neighbor arrives: the edge decision, the pixel's row and column, and
// frame_done on the last interior pixel of the frame. Border pixels give
// nothing. Three registers (threshold, width, height) are written on the cfg
// channel, which is always ready; sizes are clamped to 3..MAX on write.
// Throughput is one pixel per clock while the receiver does not stall: each
// pixel reads both line stores once at acceptance and writes them once as
// it leaves the read stage, so the single read and single write port of
// the line store set the rate. A result passes the line store read, gradient
// and squares stages, then the output register, before out_valid rises.
// Reset clears the position counters, the window and the pipeline, and loads
// threshold 60, width 640 and height 480. Line stores are not cleared.
// When the receiver stalls, the output register and the pipeline behind it
// hold; in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
`include "sobel_edge_threshold_macros.svh"

module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  set_pkg::pixel_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output set_pkg::edge_out_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [set_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [set_pkg::SIZE_W-1:0]        cfg_data
);
  import set_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);      // column / line store address
  localparam int WW = CW + 1;                 // holds the width itself
  localparam int RW = $clog2(MAX_HEIGHT) + 1; // holds the height itself

  localparam logic [WW-1:0] W_RESET =
    WW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
  localparam logic [RW-1:0] H_RESET =
    RW'((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET);

  // --------------------------------------------------------------------------
  // Configuration: the threshold is kept squared, sizes are kept clamped.
  // --------------------------------------------------------------------------
  logic [THR_SQ_W-1:0] thr_sq;
  logic [WW-1:0]       img_w;
  logic [RW-1:0]       img_h;
  logic [THR_SQ_W-1:0] thr_ext;
  logic [THR_SQ_W-1:0] thr_sq_next;
  logic [31:0]         cfg_ext;
  logic [WW-1:0]       w_clamp;
  logic [RW-1:0]       h_clamp;

  assign cfg_ready   = 1'b1;
  assign thr_ext     = THR_SQ_W'(cfg_data[THR_W-1:0]);
  assign thr_sq_next = thr_ext * thr_ext;
  assign cfg_ext     = 32'(cfg_data);
  assign w_clamp = (cfg_ext < 32'(MIN_SIZE))  ? WW'(MIN_SIZE) :
                   (cfg_ext > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_ext);
  assign h_clamp = (cfg_ext < 32'(MIN_SIZE))   ? RW'(MIN_SIZE) :
                   (cfg_ext > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq <= THR_SQ_W'(THRESHOLD_RESET * THRESHOLD_RESET);
      img_w  <= W_RESET;
      img_h  <= H_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EDGE_THRESHOLD: thr_sq <= thr_sq_next;
        CFG_IMAGE_WIDTH:    img_w  <= w_clamp;
        CFG_IMAGE_HEIGHT:   img_h  <= h_clamp;
        default: ;          // unused index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain: a stage takes new data when it is empty or moving on.
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic out_space, s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv, s3_adv, in_acc;

  assign out_space = !out_valid || out_ready;
  assign s3_free   = !s3_valid || out_space;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign in_ready  = s1_free;
  assign in_acc    = in_valid && in_ready;
  assign s1_adv    = s1_valid && s2_free;
  assign s2_adv    = s2_valid && s3_free;
  assign s3_adv    = s3_valid && out_space;

  // --------------------------------------------------------------------------
  // Position of the incoming pixel. Wrap first if the stored position lies
  // past the current size, then compute the position after this pixel.
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_count, col_next;
  logic [RW-1:0] row_count, row_next;
  logic [CW-1:0] pos_c0, pos_c;
  logic [RW-1:0] pos_r0, pos_r1, pos_r;
  logic [WW-1:0] col_inc;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] orow_m1;
  logic [CW-1:0] ocol_m1;
  logic          pos_emit, pos_last;

  always_comb begin
    pos_c0 = in_data.frame_start ? '0 : col_count;
    pos_r0 = in_data.frame_start ? '0 : row_count;
    if (WW'(pos_c0) >= img_w) begin
      pos_c  = '0;
      pos_r1 = pos_r0 + RW'(1);
    end else begin
      pos_c  = pos_c0;
      pos_r1 = pos_r0;
    end
    pos_r    = (pos_r1 >= img_h) ? '0 : pos_r1;
    pos_emit = (pos_r >= RW'(2)) && (pos_c >= CW'(2));
    pos_last = (pos_r == img_h - RW'(1)) && (WW'(pos_c) == img_w - WW'(1));
    orow_m1  = pos_r - RW'(1);
    ocol_m1  = pos_c - CW'(1);
    col_inc  = WW'(pos_c) + WW'(1);
    row_inc  = pos_r + RW'(1);
    if (col_inc >= img_w) begin
      col_next = '0;
      row_next = (row_inc >= img_h) ? '0 : row_inc;
    end else begin
      col_next = CW'(col_inc);
      row_next = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store data arrives. Read at acceptance, write back when the
  // pixel leaves this stage (upper takes the old middle, middle the pixel).
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]   rd_upper, rd_middle;
  logic [CW-1:0]      s1_col;
  logic [PIX_W-1:0]   s1_px;
  logic               s1_emit, s1_last;
  logic [COORD_W-1:0] s1_orow, s1_ocol;
  logic               fwd_hit;
  logic [PIX_W-1:0]   fwd_upper, fwd_middle;
  logic [PIX_W-1:0]   s1_top, s1_mid;

  set_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (pos_c),
    .wr_en     (s1_adv),
    .wr_addr   (s1_col),
    .wr_upper  (s1_mid),
    .wr_middle (s1_px),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  // A read that meets the write of the same entry in the same cycle sees stale
  // data; take the written values instead (repeated frame_start at column 0).
  assign s1_top = fwd_hit ? fwd_upper  : rd_upper;
  assign s1_mid = fwd_hit ? fwd_middle : rd_middle;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col     <= pos_c;
      s1_px      <= in_data.gray_pixel;
      s1_emit    <= pos_emit;
      s1_last    <= pos_last;
      s1_orow    <= COORD_W'(orow_m1);
      s1_ocol    <= COORD_W'(ocol_m1);
      fwd_hit    <= s1_adv && (s1_col == pos_c);
      fwd_upper  <= s1_mid;
      fwd_middle <= s1_px;
    end
  end

  // Two older window columns: [0..2] oldest top..bottom, [3..5] next.
  logic [PIX_W-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= s1_top;
      win[4] <= s1_mid;
      win[5] <= s1_px;
    end
  end

  function automatic logic signed [GRAD_W-1:0] sx(input logic [PIX_W-1:0] v);
    return $signed(GRAD_W'(v));
  endfunction

  logic signed [GRAD_W-1:0] gx, gy;

  // Gx: right column minus left column; Gy: lower row minus upper row.
  assign gx = (sx(s1_top) - sx(win[0])) + ((sx(s1_mid) - sx(win[1])) <<< 1)
            + (sx(s1_px) - sx(win[2]));
  assign gy = (sx(win[2]) - sx(win[0])) + ((sx(win[5]) - sx(win[3])) <<< 1)
            + (sx(s1_px) - sx(s1_top));

  // --------------------------------------------------------------------------
  // Stage 2: gradients. Stage 3: squares. Output: threshold compare.
  // --------------------------------------------------------------------------
  logic signed [GRAD_W-1:0]   s2_gx, s2_gy;
  logic [COORD_W-1:0]         s2_orow, s2_ocol, s3_orow, s3_ocol;
  logic                       s2_last, s3_last;
  logic signed [2*GRAD_W-1:0] gx_ext, gy_ext, gx_sq, gy_sq;
  logic [SQ_W-1:0]            s3_sq_x, s3_sq_y;
  logic [THR_SQ_W-1:0]        mag;

  assign gx_ext = (2*GRAD_W)'(s2_gx);
  assign gy_ext = (2*GRAD_W)'(s2_gy);
  assign gx_sq  = gx_ext * gx_ext;
  assign gy_sq  = gy_ext * gy_ext;
  assign mag    = THR_SQ_W'(s3_sq_x) + THR_SQ_W'(s3_sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_acc;
      end
      if (s2_free) begin
        s2_valid <= s1_adv && s1_emit;   // border pixels stop here
      end
      if (s3_free) begin
        s3_valid <= s2_adv;
      end
      if (out_space) begin
        out_valid <= s3_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_gx   <= gx;
      s2_gy   <= gy;
      s2_orow <= s1_orow;
      s2_ocol <= s1_ocol;
      s2_last <= s1_last;
    end
    if (s2_adv) begin
      s3_sq_x <= gx_sq[SQ_W-1:0];
      s3_sq_y <= gy_sq[SQ_W-1:0];
      s3_orow <= s2_orow;
      s3_ocol <= s2_ocol;
      s3_last <= s2_last;
    end
    if (s3_adv) begin
      out_data.edge_flag  <= (mag > thr_sq);
      out_data.out_row    <= s3_orow;
      out_data.out_col    <= s3_ocol;
      out_data.frame_done <= s3_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SET_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_valid,
                   "accepted request did not reach the read stage")
  `SET_ASSERT_NEXT(a_s1_holds, s1_valid && !s2_free,
                   s1_valid && $stable(s1_col) && $stable(s1_px),
                   "read stage changed while blocked")
  `SET_ASSERT_SAME(a_s2_source, s2_valid, $past(s1_valid) || $past(s2_valid),
                   "gradient stage filled without a source")

endmodule

// ===== rtl/core/set_line_store.sv =====
// ----------------------------------------------------------------------------
// set_line_store
// Upper and middle line stores, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module set_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [set_pkg::PIX_W-1:0] wr_upper,
  input  logic [set_pkg::PIX_W-1:0] wr_middle,
  output logic [set_pkg::PIX_W-1:0] rd_upper,
  output logic [set_pkg::PIX_W-1:0] rd_middle
);
  import set_pkg::*;

  logic [PIX_W-1:0] upper_mem  [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  // Read returns the old contents when the same entry is written this cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule
